>>> rtl/cdi_pkg.sv
// Shared types, constants and month tables for the calendar date pipeline.
// No dependencies; every other file in rtl refers to this package by scoped name.
package cdi_pkg;

  // floor(x / 25) == (x * DIV25_MUL) >> DIV25_SHIFT for every x below 43690
  localparam logic [12:0] DIV25_MUL   = 13'd5243;
  localparam int unsigned DIV25_SHIFT = 17;

  localparam logic [14:0] YEAR_OFFSET = 15'd400;
  localparam logic [8:0]  YEAR_COMMON = 9'd365;
  localparam logic [8:0]  YEAR_LEAP   = 9'd366;
  localparam logic [4:0]  FEB_LEAP    = 5'd29;
  localparam logic [3:0]  MONTH_FEB   = 4'd2;
  localparam logic [2:0]  WDAY_FRI    = 3'd5;
  localparam logic [2:0]  WDAY_SAT    = 3'd6;
  localparam logic [3:0]  MOD7        = 4'd7;

  // Stage 1 -> stage 2
  typedef struct packed {
    logic [4:0]  day;
    logic [3:0]  month;
    logic [13:0] year;
    logic [14:0] yy;      // year shifted for the weekday formula, +400
    logic [12:0] yq4;     // yy / 4
    logic [2:0]  mterm;   // (31 * shifted month / 12) mod 7
  } s1_t;

  // Stage 2 -> stage 3
  typedef struct packed {
    logic [4:0]  day;
    logic [3:0]  month;
    logic [13:0] year;
    logic [14:0] yy;
    logic [12:0] yq4;
    logic [2:0]  mterm;
    logic [7:0]  yq100x;  // yy / 100, taken as yy / 4 / 25
    logic [9:0]  y25;     // year / 25
  } s2_t;

  // Stage 3 -> stage 4
  typedef struct packed {
    logic [4:0]  day;
    logic        leap;
    logic [4:0]  dim;
    logic [8:0]  doy;
    logic [14:0] wsum;    // weekday sum before mod 7
  } s3_t;

  // Stage 4 -> stage 5
  typedef struct packed {
    logic        leap;
    logic [4:0]  dim;
    logic [8:0]  doy;
    logic [4:0]  lim;
    logic [8:0]  liy;
    logic [5:0]  fold;    // octal digit sum of wsum, same residue mod 7
  } s4_t;

  // Days before each month in a common year
  function automatic logic [8:0] cum_days(input logic [3:0] m);
    logic [8:0] r;
    unique case (m)
      4'd0:    r = 9'd0;
      4'd1:    r = 9'd0;
      4'd2:    r = 9'd31;
      4'd3:    r = 9'd59;
      4'd4:    r = 9'd90;
      4'd5:    r = 9'd120;
      4'd6:    r = 9'd151;
      4'd7:    r = 9'd181;
      4'd8:    r = 9'd212;
      4'd9:    r = 9'd243;
      4'd10:   r = 9'd273;
      4'd11:   r = 9'd304;
      4'd12:   r = 9'd334;
      default: r = 9'd365;
    endcase
    return r;
  endfunction

  // Month length in a common year, 0 for codes that are not a month
  function automatic logic [4:0] month_len(input logic [3:0] m);
    logic [4:0] r;
    unique case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: r = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                     r = 5'd30;
      4'd2:                                        r = 5'd28;
      default:                                     r = 5'd0;
    endcase
    return r;
  endfunction

  // Month term of the weekday formula, reduced mod 7
  function automatic logic [2:0] month_term(input logic [3:0] m);
    logic [2:0] r;
    unique case (m)
      4'd0:    r = 3'd4;
      4'd1:    r = 3'd0;
      4'd2:    r = 3'd3;
      4'd3:    r = 3'd2;
      4'd4:    r = 3'd5;
      4'd5:    r = 3'd0;
      4'd6:    r = 3'd3;
      4'd7:    r = 3'd5;
      4'd8:    r = 3'd1;
      4'd9:    r = 3'd4;
      4'd10:   r = 3'd6;
      4'd11:   r = 3'd2;
      4'd12:   r = 3'd4;
      4'd13:   r = 3'd0;
      4'd14:   r = 3'd3;
      default: r = 3'd5;
    endcase
    return r;
  endfunction

endpackage

>>> rtl/cdi_front.sv
// Stage 1: input register of the date pipeline; shifts the year and looks up the month term.
// Depends on cdi_pkg.
module cdi_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  output logic              ready_o,
  input  logic [4:0]        day_num_i,
  input  logic [3:0]        month_num_i,
  input  logic [13:0]       year_num_i,
  output logic              valid_o,
  input  logic              ready_i,
  output cdi_pkg::s1_t      data_o
);

  logic         vld_q;
  cdi_pkg::s1_t data_d, data_q;
  logic         early;

  assign ready_o = !vld_q || ready_i;
  assign valid_o = vld_q;
  assign data_o  = data_q;

  always_comb begin
    // January and February count as months of the previous year
    early         = (month_num_i <= cdi_pkg::MONTH_FEB);
    data_d.day    = day_num_i;
    data_d.month  = month_num_i;
    data_d.year   = year_num_i;
    data_d.yy     = {1'b0, year_num_i} + cdi_pkg::YEAR_OFFSET - {14'd0, early};
    data_d.yq4    = data_d.yy[14:2];
    data_d.mterm  = cdi_pkg::month_term(month_num_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (ready_o) begin
      vld_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_d;
    end
  end

endmodule

>>> rtl/cdi_divide.sv
// Stage 2: divisions by 25 through reciprocal multiplication, for the weekday and leap terms.
// Depends on cdi_pkg.
module cdi_divide (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  output logic              ready_o,
  input  cdi_pkg::s1_t      data_i,
  output logic              valid_o,
  input  logic              ready_i,
  output cdi_pkg::s2_t      data_o
);

  logic         vld_q;
  cdi_pkg::s2_t data_d, data_q;
  logic [25:0]  prod_w;
  logic [26:0]  prod_y;

  assign ready_o = !vld_q || ready_i;
  assign valid_o = vld_q;
  assign data_o  = data_q;

  always_comb begin
    prod_w        = data_i.yq4 * cdi_pkg::DIV25_MUL;
    prod_y        = {13'd0, data_i.year} * {14'd0, cdi_pkg::DIV25_MUL};
    data_d.day    = data_i.day;
    data_d.month  = data_i.month;
    data_d.year   = data_i.year;
    data_d.yy     = data_i.yy;
    data_d.yq4    = data_i.yq4;
    data_d.mterm  = data_i.mterm;
    data_d.yq100x = prod_w[cdi_pkg::DIV25_SHIFT +: 8];
    data_d.y25    = prod_y[cdi_pkg::DIV25_SHIFT +: 10];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (ready_o) begin
      vld_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_d;
    end
  end

endmodule

>>> rtl/cdi_accum.sv
// Stage 3: leap flag, month length, day of year and the weekday sum.
// Depends on cdi_pkg.
module cdi_accum (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  output logic              ready_o,
  input  cdi_pkg::s2_t      data_i,
  output logic              valid_o,
  input  logic              ready_i,
  output cdi_pkg::s3_t      data_o
);

  logic         vld_q;
  cdi_pkg::s3_t data_d, data_q;
  logic [13:0]  y25x25;
  logic         div4, div100, div400;
  logic [15:0]  sum;

  assign ready_o = !vld_q || ready_i;
  assign valid_o = vld_q;
  assign data_o  = data_q;

  always_comb begin
    y25x25 = {data_i.y25, 4'd0} + {1'b0, data_i.y25, 3'd0} + {4'd0, data_i.y25};
    div4   = (data_i.year[1:0] == 2'd0);
    div100 = div4 && (y25x25 == data_i.year);
    // year / 100 is y25 / 4, so divisible by 400 when its low two bits are clear
    div400 = div100 && (data_i.y25[3:2] == 2'd0);

    data_d.day  = data_i.day;
    data_d.leap = div400 || (div4 && !div100);

    data_d.dim = cdi_pkg::month_len(data_i.month);
    if (data_d.leap && data_i.month == cdi_pkg::MONTH_FEB) begin
      data_d.dim = cdi_pkg::FEB_LEAP;
    end

    data_d.doy = cdi_pkg::cum_days(data_i.month) + {4'd0, data_i.day};
    if (data_d.leap && data_i.month > cdi_pkg::MONTH_FEB) begin
      data_d.doy = data_d.doy + 9'd1;
    end

    // d + yy + yy/4 - yy/100 + yy/400 + month term
    sum = {11'd0, data_i.day} + {1'b0, data_i.yy} + {3'd0, data_i.yq4}
        + {10'd0, data_i.yq100x[7:2]} + {13'd0, data_i.mterm}
        - {8'd0, data_i.yq100x};
    data_d.wsum = sum[14:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (ready_o) begin
      vld_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_d;
    end
  end

endmodule

>>> rtl/cdi_remain.sv
// Stage 4: days left in month and year, first mod-7 fold of the weekday sum.
// Depends on cdi_pkg.
module cdi_remain (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  output logic              ready_o,
  input  cdi_pkg::s3_t      data_i,
  output logic              valid_o,
  input  logic              ready_i,
  output cdi_pkg::s4_t      data_o
);

  logic         vld_q;
  cdi_pkg::s4_t data_d, data_q;
  logic [8:0]   ylen;

  assign ready_o = !vld_q || ready_i;
  assign valid_o = vld_q;
  assign data_o  = data_q;

  always_comb begin
    ylen        = data_i.leap ? cdi_pkg::YEAR_LEAP : cdi_pkg::YEAR_COMMON;
    data_d.leap = data_i.leap;
    data_d.dim  = data_i.dim;
    data_d.doy  = data_i.doy;
    data_d.lim  = (data_i.dim > data_i.day) ? data_i.dim - data_i.day : 5'd0;
    data_d.liy  = (ylen > data_i.doy) ? ylen - data_i.doy : 9'd0;
    // 8 is 1 mod 7: summing octal digits keeps the residue
    data_d.fold = {3'd0, data_i.wsum[2:0]}   + {3'd0, data_i.wsum[5:3]}
                + {3'd0, data_i.wsum[8:6]}   + {3'd0, data_i.wsum[11:9]}
                + {3'd0, data_i.wsum[14:12]};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (ready_o) begin
      vld_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_d;
    end
  end

endmodule

>>> rtl/cdi_wday.sv
// Stage 5: output register; final mod-7 reduction and the weekday flags.
// Depends on cdi_pkg.
module cdi_wday (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  output logic              ready_o,
  input  cdi_pkg::s4_t      data_i,
  output logic              valid_o,
  input  logic              ready_i,
  output logic [2:0]        weekday_o,
  output logic              leap_year_o,
  output logic [4:0]        days_in_month_o,
  output logic [8:0]        day_of_year_o,
  output logic [2:0]        left_in_week_o,
  output logic [4:0]        left_in_month_o,
  output logic [8:0]        left_in_year_o,
  output logic              end_of_week_o,
  output logic              weekend_day_o,
  output logic              business_day_o
);

  logic       vld_q;
  logic [3:0] res;
  logic [3:0] wd_full;
  logic [2:0] wd_d;
  logic       wkend_d;

  logic [2:0] wd_q, liw_q;
  logic       leap_q, eow_q, wkend_q, bus_q;
  logic [4:0] dim_q, lim_q;
  logic [8:0] doy_q, liy_q;

  assign ready_o = !vld_q || ready_i;
  assign valid_o = vld_q;

  always_comb begin
    // fold is at most 35, so one more digit sum is at most 11
    res     = {1'b0, data_i.fold[5:3]} + {1'b0, data_i.fold[2:0]};
    wd_full = (res >= cdi_pkg::MOD7) ? res - cdi_pkg::MOD7 : res;
    wd_d    = wd_full[2:0];
    wkend_d = (wd_d == cdi_pkg::WDAY_FRI) || (wd_d == cdi_pkg::WDAY_SAT);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (ready_o) begin
      vld_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      wd_q    <= wd_d;
      liw_q   <= cdi_pkg::WDAY_SAT - wd_d;
      leap_q  <= data_i.leap;
      dim_q   <= data_i.dim;
      doy_q   <= data_i.doy;
      lim_q   <= data_i.lim;
      liy_q   <= data_i.liy;
      eow_q   <= (wd_d == cdi_pkg::WDAY_SAT);
      wkend_q <= wkend_d;
      bus_q   <= !wkend_d;
    end
  end

  assign weekday_o       = wd_q;
  assign leap_year_o     = leap_q;
  assign days_in_month_o = dim_q;
  assign day_of_year_o   = doy_q;
  assign left_in_week_o  = liw_q;
  assign left_in_month_o = lim_q;
  assign left_in_year_o  = liy_q;
  assign end_of_week_o   = eow_q;
  assign weekend_day_o   = wkend_q;
  assign business_day_o  = bus_q;

endmodule

>>> rtl/calendar_date_info_top.sv
// Calendar date facts: takes one Gregorian date word per cycle, unless held by back-pressure,
// and returns weekday, leap flag, month length, day of year, days left in week/month/year and
// weekend/business-day flags. Five register stages (input, divide-by-25 multipliers, sums,
// remainders, output); a new date is taken every cycle unless back-pressure holds the input.
// Back-pressure on out_ready_i holds every stage in place; bubbles are filled as they reach a
// stage. Depends on cdi_pkg, cdi_front, cdi_divide, cdi_accum, cdi_remain and cdi_wday.
module calendar_date_info_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [4:0]  day_num_i,
  input  logic [3:0]  month_num_i,
  input  logic [13:0] year_num_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  weekday_o,
  output logic        leap_year_o,
  output logic [4:0]  days_in_month_o,
  output logic [8:0]  day_of_year_o,
  output logic [2:0]  left_in_week_o,
  output logic [4:0]  left_in_month_o,
  output logic [8:0]  left_in_year_o,
  output logic        end_of_week_o,
  output logic        weekend_day_o,
  output logic        business_day_o
);

  cdi_pkg::s1_t s1;
  cdi_pkg::s2_t s2;
  cdi_pkg::s3_t s3;
  cdi_pkg::s4_t s4;
  logic v1, v2, v3, v4;
  logic r2, r3, r4, r5;

  cdi_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (in_valid_i),
    .ready_o     (in_ready_o),
    .day_num_i   (day_num_i),
    .month_num_i (month_num_i),
    .year_num_i  (year_num_i),
    .valid_o     (v1),
    .ready_i     (r2),
    .data_o      (s1)
  );

  cdi_divide u_divide (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (v1),
    .ready_o (r2),
    .data_i  (s1),
    .valid_o (v2),
    .ready_i (r3),
    .data_o  (s2)
  );

  cdi_accum u_accum (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (v2),
    .ready_o (r3),
    .data_i  (s2),
    .valid_o (v3),
    .ready_i (r4),
    .data_o  (s3)
  );

  cdi_remain u_remain (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (v3),
    .ready_o (r4),
    .data_i  (s3),
    .valid_o (v4),
    .ready_i (r5),
    .data_o  (s4)
  );

  cdi_wday u_wday (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .valid_i         (v4),
    .ready_o         (r5),
    .data_i          (s4),
    .valid_o         (out_valid_o),
    .ready_i         (out_ready_i),
    .weekday_o       (weekday_o),
    .leap_year_o     (leap_year_o),
    .days_in_month_o (days_in_month_o),
    .day_of_year_o   (day_of_year_o),
    .left_in_week_o  (left_in_week_o),
    .left_in_month_o (left_in_month_o),
    .left_in_year_o  (left_in_year_o),
    .end_of_week_o   (end_of_week_o),
    .weekend_day_o   (weekend_day_o),
    .business_day_o  (business_day_o)
  );

endmodule

>>> tb/testbench.sv
// Self-checking testbench for calendar_date_info_top: drives date words and checks every fact.
// Depends on cdi_pkg and the RTL under rtl; a scoreboard class predicts results in order.
`timescale 1ns / 100ps

module testbench;

  localparam int unsigned PIPE_DEPTH  = 5;
  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned RANDOM_PER_PHASE = 483;

  // Common-year tables, indexed by the full 4-bit month code
  localparam int unsigned DAYS_BEFORE [16] = '{
    0, 0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334, 365, 365, 365
  };
  localparam int unsigned MONTH_DAYS [16] = '{
    0, 31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31, 0, 0, 0
  };

  typedef struct packed {
    logic [2:0] weekday;
    logic       leap_year;
    logic [4:0] days_in_month;
    logic [8:0] day_of_year;
    logic [2:0] left_in_week;
    logic [4:0] left_in_month;
    logic [8:0] left_in_year;
    logic       end_of_week;
    logic       weekend_day;
    logic       business_day;
  } date_facts_t;

  function automatic bit is_leap(int unsigned y);
    return (y % 400 == 0) || (y % 4 == 0 && y % 100 != 0);
  endfunction

  function automatic int unsigned month_length(int unsigned m, int unsigned y);
    if (m == cdi_pkg::MONTH_FEB && is_leap(y)) return cdi_pkg::FEB_LEAP;
    return MONTH_DAYS[m];
  endfunction

  class date_scoreboard;
    date_facts_t facts_q[$];
    int unsigned errors;

    static function date_facts_t predict_facts(logic [4:0] d, logic [3:0] m,
                                               logic [13:0] y);
      int unsigned dd, mm, yy, early, wd, dim, doy, ylen;
      bit          leap;
      date_facts_t f;
      dd    = d;
      leap  = is_leap(y);
      // Jan/Feb (and month zero) count as months 11/12 of the year before
      early = (m <= cdi_pkg::MONTH_FEB) ? 1 : 0;
      yy    = y + 400 - early;
      mm    = m + 12 * early - 2;
      wd    = (dd + yy + yy / 4 - yy / 100 + yy / 400 + (31 * mm) / 12) % 7;
      dim   = month_length(m, y);
      doy   = DAYS_BEFORE[m] + dd + ((leap && m > cdi_pkg::MONTH_FEB) ? 1 : 0);
      ylen  = leap ? cdi_pkg::YEAR_LEAP : cdi_pkg::YEAR_COMMON;
      f.weekday       = wd[2:0];
      f.leap_year     = leap;
      f.days_in_month = dim[4:0];
      f.day_of_year   = doy[8:0];
      f.left_in_week  = 3'(6 - wd);
      f.left_in_month = (dim > dd) ? 5'(dim - dd) : 5'd0;
      f.left_in_year  = (ylen > doy) ? 9'(ylen - doy) : 9'd0;
      f.end_of_week   = (wd == cdi_pkg::WDAY_SAT);
      f.weekend_day   = (wd == cdi_pkg::WDAY_FRI) || (wd == cdi_pkg::WDAY_SAT);
      f.business_day  = !f.weekend_day;
      return f;
    endfunction

    function void note_date(logic [4:0] d, logic [3:0] m, logic [13:0] y);
      facts_q.push_back(predict_facts(d, m, y));
    endfunction

    function void compare_field(string name, int unsigned exp_v, int unsigned got_v);
      if (exp_v != got_v) begin
        $error("%s: expected %0d, got %0d", name, exp_v, got_v);
        errors++;
      end
    endfunction

    function void check_result(date_facts_t got);
      date_facts_t exp_f;
      if (facts_q.size() == 0) begin
        $error("result word with nothing expected");
        errors++;
        return;
      end
      exp_f = facts_q.pop_front();
      compare_field("weekday",       exp_f.weekday,       got.weekday);
      compare_field("leap_year",     exp_f.leap_year,     got.leap_year);
      compare_field("days_in_month", exp_f.days_in_month, got.days_in_month);
      compare_field("day_of_year",   exp_f.day_of_year,   got.day_of_year);
      compare_field("left_in_week",  exp_f.left_in_week,  got.left_in_week);
      compare_field("left_in_month", exp_f.left_in_month, got.left_in_month);
      compare_field("left_in_year",  exp_f.left_in_year,  got.left_in_year);
      compare_field("end_of_week",   exp_f.end_of_week,   got.end_of_week);
      compare_field("weekend_day",   exp_f.weekend_day,   got.weekend_day);
      compare_field("business_day",  exp_f.business_day,  got.business_day);
    endfunction

    function int unsigned pending();
      return facts_q.size();
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [4:0]  day_num_i = '0;
  logic [3:0]  month_num_i = '0;
  logic [13:0] year_num_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [2:0]  weekday_o;
  logic        leap_year_o;
  logic [4:0]  days_in_month_o;
  logic [8:0]  day_of_year_o;
  logic [2:0]  left_in_week_o;
  logic [4:0]  left_in_month_o;
  logic [8:0]  left_in_year_o;
  logic        end_of_week_o;
  logic        weekend_day_o;
  logic        business_day_o;

  date_scoreboard board = new();
  int unsigned    send_idle_pct = 0;
  int unsigned    recv_idle_pct = 0;
  int unsigned    cycle_count   = 0;

  calendar_date_info_top dut (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_ready_o,
    .day_num_i,
    .month_num_i,
    .year_num_i,
    .out_valid_o,
    .out_ready_i,
    .weekday_o,
    .leap_year_o,
    .days_in_month_o,
    .day_of_year_o,
    .left_in_week_o,
    .left_in_month_o,
    .left_in_year_o,
    .end_of_week_o,
    .weekend_day_o,
    .business_day_o
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("** calendar_date_info_top: FAILED **");
      $finish;
    end
  end

  // Receiver: ready changes on the falling edge only
  always @(negedge clk_i) begin
    out_ready_i <= rst_ni && ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) board.note_date(day_num_i, month_num_i, year_num_i);
      if (out_valid_o && out_ready_i) begin
        board.check_result('{weekday_o, leap_year_o, days_in_month_o, day_of_year_o,
                             left_in_week_o, left_in_month_o, left_in_year_o,
                             end_of_week_o, weekend_day_o, business_day_o});
      end
    end
  end

  // Called at a falling edge; returns at the falling edge after the word is taken
  task automatic send_date(logic [4:0] d, logic [3:0] m, logic [13:0] y);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i  = 1'b1;
    day_num_i   = d;
    month_num_i = m;
    year_num_i  = y;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // Hold the sender off until the pipe has emptied
  task automatic drain_pipe();
    in_valid_i = 1'b0;
    while (board.pending() != 0) @(negedge clk_i);
  endtask

  task automatic send_random_date();
    int unsigned m, y;
    if ($urandom_range(99) < 80) begin
      m = $urandom_range(12, 1);
      y = $urandom_range(9999, 1);
      // bias a little towards the last day of the month
      if ($urandom_range(9) == 0)
        send_date(5'(month_length(m, y)), 4'(m), 14'(y));
      else
        send_date(5'($urandom_range(month_length(m, y), 1)), 4'(m), 14'(y));
    end else begin
      send_date(5'($urandom), 4'($urandom), 14'($urandom));
    end
  endtask

  initial begin
    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    send_idle_pct = 12;
    recv_idle_pct = 56;
    send_date(5'd1,  4'd1,  14'd1);      // earliest date
    send_date(5'd31, 4'd12, 14'd9999);   // latest date
    send_date(5'd0,  4'd0,  14'd0);      // all fields zero
    send_date(5'd31, 4'd15, 14'd16383);  // all bits set
    send_date(5'd29, 4'd2,  14'd2000);   // leap by the 400 rule
    send_date(5'd29, 4'd2,  14'd1900);   // century not leap, day past month end
    send_date(5'd28, 4'd2,  14'd2023);
    send_date(5'd29, 4'd2,  14'd2024);
    send_date(5'd31, 4'd12, 14'd2024);   // last day of a leap year
    send_date(5'd31, 4'd12, 14'd2023);
    send_date(5'd1,  4'd3,  14'd2024);   // first day after a leap Feb
    send_date(5'd15, 4'd0,  14'd2021);   // month zero
    send_date(5'd1,  4'd13, 14'd2021);   // months past December
    send_date(5'd10, 4'd14, 14'd2020);
    send_date(5'd31, 4'd15, 14'd2001);
    send_date(5'd0,  4'd6,  14'd1999);   // day zero
    send_date(5'd31, 4'd4,  14'd2010);   // day past a 30-day month
    send_date(5'd31, 4'd2,  14'd2001);
    send_date(5'd1,  4'd1,  14'd0);      // year zero, leap
    send_date(5'd29, 4'd2,  14'd0);
    send_date(5'd5,  4'd7,  14'd10000);  // beyond 9999
    send_date(5'd1,  4'd1,  14'd16383);
    send_date(5'd13, 4'd1,  14'd2023);   // Fri, Sat, Sun in a row
    send_date(5'd14, 4'd1,  14'd2023);
    send_date(5'd15, 4'd1,  14'd2023);
    drain_pipe();

    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 12 : (phase == 1) ? 56 : 0;
      recv_idle_pct = (phase == 0) ? 56 : (phase == 1) ? 12 : 0;
      for (int n = 0; n < RANDOM_PER_PHASE; n++) send_random_date();
      drain_pipe();
    end

    repeat (PIPE_DEPTH * 4) @(posedge clk_i);
    if (board.errors == 0 && board.pending() == 0) begin
      $display("** calendar_date_info_top: PASSED **");
    end else begin
      $display("** calendar_date_info_top: FAILED **");
    end
    $finish;
  end

endmodule
